// ===== sv/mf3_pkg.sv =====
// -----------------------------------------------------------------------------
// mf3_pkg: shared types and constants of the 3x3 median filter
// Field widths, configuration register codes and the work item passed from
// the front end to the back end.
// -----------------------------------------------------------------------------
package mf3_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned CFG_W       = 11;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned COMP_W      = 3;
  localparam int unsigned COL_W       = 12;
  localparam int unsigned ROW_W       = 11;
  localparam int unsigned LEN_W       = 13;
  localparam int unsigned MAX_DIM     = 1024;
  localparam int unsigned MAX_COMP    = 4;
  localparam int unsigned MAX_LEN     = 4096;
  localparam int unsigned WIN_N       = 9;
  localparam int unsigned TAP_N       = 8;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_COMPS  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_FLUSH  = 1'b1
  } op_e;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [WIN_N-1:0] win_t;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } border_t;

  typedef struct packed {
    pix_t             value;
    logic [COL_W-1:0] col;
    logic [1:0]       comp;
    logic             emit;
    border_t          border;
    logic             last;
  } work_item_t;

endpackage

// ===== sv/median_filter_3x3_core.sv =====
// -----------------------------------------------------------------------------
// median_filter_3x3_core: 3x3 median filter over an interleaved pixel stream
//
//   channel  direction  fields
//   s_axis   in         tdata: sample[7:0]; tuser: operation (1 = flush)
//   m_axis   out        tdata: median_value[7:0]; tlast: frame_end
//   cfg      in         index 0 width, 1 height, 2 component count
//
// One item per clock sustained while the output accepts; the line stores take
// one read and one write per item each. A median's tvalid rises once the item
// that completes its neighbourhood has passed the queue write, two line store
// reads, window, three sort stages and the output register. Reset clears counters,
// queue and valid flags; the line stores need no clearing. A stalled output
// freezes the back end; the four-entry queue keeps tready high until it fills.
// -----------------------------------------------------------------------------
module median_filter_3x3_core #(
  parameter int unsigned MAX_LINE = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mf3_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mf3_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [mf3_pkg::PIX_W-1:0]     s_axis_tdata_i,  // [7:0] sample
  input  logic                          s_axis_tuser_i,  // [0] operation
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [mf3_pkg::PIX_W-1:0]     m_axis_tdata_o,  // [7:0] median_value
  output logic                          m_axis_tlast_o
);
  import mf3_pkg::*;

  work_item_t push_item, head_item;
  logic       q_push, q_pop, q_full, q_valid;

  mf3_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_op_i     (s_axis_tuser_i),
    .in_sample_i (s_axis_tdata_i),
    .in_ready_o  (s_axis_tready_o),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .item_o      (push_item)
  );

  mf3_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (head_item)
  );

  mf3_back #(
    .MAX_LINE (MAX_LINE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .head_i       (head_item),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_median_o (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o)
  );

  a_full_needs_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> $past(m_axis_tvalid_o && !m_axis_tready_i))
    else $error("queue full without an output stall");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from an empty queue");

  a_pop_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("back end advanced during an output stall");

endmodule

// ===== sv/mf3_front.sv =====
// -----------------------------------------------------------------------------
// mf3_front: configuration registers and stream position tracking
// Accepts samples, works out the padding value, line address, border flags
// and frame end for each one, and hands a work item to the queue.
// -----------------------------------------------------------------------------
module mf3_front #(
  parameter int unsigned MAX_LINE = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mf3_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mf3_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_op_i,
  input  mf3_pkg::pix_t                 in_sample_i,
  output logic                          in_ready_o,
  input  logic                          q_full_i,
  output logic                          push_o,
  output mf3_pkg::work_item_t           item_o
);
  import mf3_pkg::*;

  localparam int unsigned CapW1 = (MAX_LINE / 1 < 1) ? 1 : MAX_LINE / 1;
  localparam int unsigned CapW2 = (MAX_LINE / 2 < 1) ? 1 : MAX_LINE / 2;
  localparam int unsigned CapW3 = (MAX_LINE / 3 < 1) ? 1 : MAX_LINE / 3;
  localparam int unsigned CapW4 = (MAX_LINE / 4 < 1) ? 1 : MAX_LINE / 4;
  localparam logic [LEN_W-1:0] CapLen1 = LEN_W'(CapW1 * 1);
  localparam logic [LEN_W-1:0] CapLen2 = LEN_W'(CapW2 * 2);
  localparam logic [LEN_W-1:0] CapLen3 = LEN_W'(CapW3 * 3);
  localparam logic [LEN_W-1:0] CapLen4 = LEN_W'(CapW4 * 4);
  localparam logic [LEN_W+1:0] MaxLineV = (LEN_W + 2)'(MAX_LINE);

  logic [CFG_W-1:0]  width_q, height_q;
  logic [COMP_W-1:0] comps_q;

  logic [COL_W-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d, out_row_q, out_row_d;

  logic [COMP_W-1:0] comp_c;
  logic [CFG_W-1:0]  width_c, height_c;
  logic [LEN_W:0]    line_prod;
  logic [LEN_W-1:0]  cap_len, len_c;
  logic              accept, emit, col_wrap, out_col_last, out_row_last, last;
  border_t           border;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(64);
      height_q <= CFG_W'(64);
      comps_q  <= COMP_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_WIDTH:  width_q  <= cfg_wdata_i;
        REG_HEIGHT: height_q <= cfg_wdata_i;
        REG_COMPS:  comps_q  <= cfg_wdata_i[COMP_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the registers to their working ranges
  always_comb begin
    priority if (comps_q == '0) begin
      comp_c = COMP_W'(1);
    end else if (comps_q > COMP_W'(MAX_COMP)) begin
      comp_c = COMP_W'(MAX_COMP);
    end else begin
      comp_c = comps_q;
    end
    priority if (width_q == '0) begin
      width_c = CFG_W'(1);
    end else if (width_q > CFG_W'(MAX_DIM)) begin
      width_c = CFG_W'(MAX_DIM);
    end else begin
      width_c = width_q;
    end
    priority if (height_q == '0) begin
      height_c = CFG_W'(1);
    end else if (height_q > CFG_W'(MAX_DIM)) begin
      height_c = CFG_W'(MAX_DIM);
    end else begin
      height_c = height_q;
    end
    unique case (comp_c)
      3'd2:    cap_len = CapLen2;
      3'd3:    cap_len = CapLen3;
      3'd4:    cap_len = CapLen4;
      default: cap_len = CapLen1;
    endcase
    line_prod = (LEN_W + 1)'(width_c) * (LEN_W + 1)'(comp_c);
    len_c     = ({1'b0, line_prod} > MaxLineV) ? cap_len : line_prod[LEN_W-1:0];
  end

  assign accept     = in_valid_i & ~q_full_i;
  assign in_ready_o = ~q_full_i;
  assign push_o     = accept;

  always_comb begin
    emit = (in_row_q >= ROW_W'(2)) ||
           ((in_row_q == ROW_W'(1)) && (in_col_q >= COL_W'(comp_c)));
    col_wrap     = (LEN_W'(in_col_q) + LEN_W'(1)) >= len_c;
    out_col_last = (LEN_W'(out_col_q) + LEN_W'(1)) >= len_c;
    out_row_last = ((ROW_W + 1)'(out_row_q) + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(height_c);
    last         = out_col_last & out_row_last;

    border.top    = out_row_q != '0;
    border.bottom = ~out_row_last;
    border.left   = out_col_q >= COL_W'(comp_c);
    border.right  = (LEN_W'(out_col_q) + LEN_W'(comp_c)) < len_c;

    item_o.value  = ((op_e'(in_op_i) == OP_SAMPLE) && (in_row_q < height_c)) ?
                    in_sample_i : '0;
    item_o.col    = in_col_q;
    item_o.comp   = 2'(comp_c - COMP_W'(1));
    item_o.emit   = emit;
    item_o.border = border;
    item_o.last   = last;
  end

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (accept) begin
      if (col_wrap) begin
        in_col_d = '0;
        if (in_row_q != '1) begin
          in_row_d = in_row_q + ROW_W'(1);
        end
      end else begin
        in_col_d = in_col_q + COL_W'(1);
      end
      if (emit) begin
        priority if (last) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (out_col_last) begin
          out_col_d = '0;
          if (out_row_q != '1) begin
            out_row_d = out_row_q + ROW_W'(1);
          end
        end else begin
          out_col_d = out_col_q + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

endmodule

// ===== sv/mf3_queue.sv =====
// -----------------------------------------------------------------------------
// mf3_queue: work item queue between front end and back end
// Small register FIFO; lets the input side run on while the back end stalls.
// -----------------------------------------------------------------------------
module mf3_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mf3_pkg::work_item_t item_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                valid_o,
  output mf3_pkg::work_item_t head_o
);
  import mf3_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  work_item_t        slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]     count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q + (PtrW + 1)'(push_i) - (PtrW + 1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  assign full_o  = count_q == (PtrW + 1)'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = slot_q[rd_ptr_q];

endmodule

// ===== sv/mf3_sort.sv =====
// -----------------------------------------------------------------------------
// mf3_sort: pipelined median-of-nine network
// Nineteen compare-exchange cells split over three register stages.
// -----------------------------------------------------------------------------
module mf3_sort (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic          last_i,
  input  mf3_pkg::win_t win_i,
  output logic          valid_o,
  output logic          last_o,
  output mf3_pkg::pix_t median_o
);
  import mf3_pkg::*;

  win_t st1_q, st2_q, st1_d, st2_d;
  pix_t med_q, med_d;
  logic v1_q, v2_q, v3_q;
  logic l1_q, l2_q, l3_q;

  function automatic win_t cas(win_t w, int unsigned a, int unsigned b);
    win_t r;
    r = w;
    if (w[a] > w[b]) begin
      r[a] = w[b];
      r[b] = w[a];
    end
    return r;
  endfunction

  always_comb begin
    win_t p;
    // sort each row of three
    p = win_i;
    p = cas(p, 1, 2); p = cas(p, 4, 5); p = cas(p, 7, 8);
    p = cas(p, 0, 1); p = cas(p, 3, 4); p = cas(p, 6, 7);
    p = cas(p, 1, 2); p = cas(p, 4, 5); p = cas(p, 7, 8);
    st1_d = p;
  end

  always_comb begin
    win_t p;
    p = st1_q;
    p = cas(p, 0, 3); p = cas(p, 5, 8); p = cas(p, 4, 7);
    p = cas(p, 3, 6); p = cas(p, 1, 4); p = cas(p, 2, 5);
    st2_d = p;
  end

  always_comb begin
    win_t p;
    p = st2_q;
    p = cas(p, 4, 7); p = cas(p, 4, 2); p = cas(p, 6, 4); p = cas(p, 4, 2);
    med_d = p[4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st1_q <= st1_d;
      st2_q <= st2_d;
      med_q <= med_d;
      l1_q  <= last_i;
      l2_q  <= l1_q;
      l3_q  <= l2_q;
    end
  end

  assign valid_o  = v3_q;
  assign last_o   = l3_q;
  assign median_o = med_q;

endmodule

// ===== sv/mf3_back.sv =====
// -----------------------------------------------------------------------------
// mf3_back: line stores, window assembly, median and output register
// Two cascaded line stores give the rows above, short shift lines give the
// same component one and two pixels back; border flags zero the padding.
// -----------------------------------------------------------------------------
module mf3_back #(
  parameter int unsigned MAX_LINE = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  mf3_pkg::work_item_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mf3_pkg::pix_t       out_median_o,
  output logic                out_last_o
);
  import mf3_pkg::*;

  localparam int unsigned LineDepth = (MAX_LINE < MAX_COMP) ? MAX_COMP :
                                      (MAX_LINE > MAX_LEN) ? MAX_LEN : MAX_LINE;
  localparam int unsigned AddrW = $clog2(LineDepth);

  typedef pix_t [TAP_N-1:0] tap_line_t;

  pix_t middle_mem [LineDepth];
  pix_t upper_mem  [LineDepth];

  logic       adv, pop;
  logic       s1_valid_q, s2_valid_q, win_valid_q, out_valid_q;
  work_item_t s1_item_q, s2_item_q;
  pix_t       mid_rd_q, up_rd_q, s2_mid_q;
  tap_line_t  bot_sr_q, mid_sr_q, top_sr_q;
  win_t       win_d, win_q;
  logic       win_last_q;
  logic       med_valid, med_last;
  pix_t       med_value;
  pix_t       out_median_q;
  logic       out_last_q;

  function automatic pix_t tap_near(tap_line_t sr, logic [1:0] comp);
    pix_t r;
    unique case (comp)
      2'd0: r = sr[0];
      2'd1: r = sr[1];
      2'd2: r = sr[2];
      2'd3: r = sr[3];
    endcase
    return r;
  endfunction

  function automatic pix_t tap_far(tap_line_t sr, logic [1:0] comp);
    pix_t r;
    unique case (comp)
      2'd0: r = sr[1];
      2'd1: r = sr[3];
      2'd2: r = sr[5];
      2'd3: r = sr[7];
    endcase
    return r;
  endfunction

  function automatic pix_t keep(pix_t v, logic en);
    return en ? v : '0;
  endfunction

  assign adv   = ~out_valid_q | out_ready_i;
  assign pop   = adv & q_valid_i;
  assign pop_o = pop;

  // first line store: one row back
  always_ff @(posedge clk_i) begin
    if (pop) begin
      mid_rd_q                         <= middle_mem[head_i.col[AddrW-1:0]];
      middle_mem[head_i.col[AddrW-1:0]] <= head_i.value;
    end
  end

  // second line store: two rows back
  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      up_rd_q                           <= upper_mem[s1_item_q.col[AddrW-1:0]];
      upper_mem[s1_item_q.col[AddrW-1:0]] <= mid_rd_q;
    end
  end

  always_comb begin
    border_t b;
    logic [1:0] cp;
    b  = s2_item_q.border;
    cp = s2_item_q.comp;
    win_d[0] = keep(tap_far(top_sr_q, cp),  b.top & b.left);
    win_d[1] = keep(tap_near(top_sr_q, cp), b.top);
    win_d[2] = keep(up_rd_q,                b.top & b.right);
    win_d[3] = keep(tap_far(mid_sr_q, cp),  b.left);
    win_d[4] = tap_near(mid_sr_q, cp);
    win_d[5] = keep(s2_mid_q,               b.right);
    win_d[6] = keep(tap_far(bot_sr_q, cp),  b.bottom & b.left);
    win_d[7] = keep(tap_near(bot_sr_q, cp), b.bottom);
    win_d[8] = keep(s2_item_q.value,        b.bottom & b.right);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      win_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= q_valid_i;
      s2_valid_q  <= s1_valid_q;
      win_valid_q <= s2_valid_q & s2_item_q.emit;
      out_valid_q <= med_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_item_q <= head_i;
    end
    if (adv && s1_valid_q) begin
      s2_item_q <= s1_item_q;
      s2_mid_q  <= mid_rd_q;
    end
    if (adv && s2_valid_q) begin
      bot_sr_q   <= {bot_sr_q[TAP_N-2:0], s2_item_q.value};
      mid_sr_q   <= {mid_sr_q[TAP_N-2:0], s2_mid_q};
      top_sr_q   <= {top_sr_q[TAP_N-2:0], up_rd_q};
      win_q      <= win_d;
      win_last_q <= s2_item_q.last;
    end
    if (adv && med_valid) begin
      out_median_q <= med_value;
      out_last_q   <= med_last;
    end
  end

  mf3_sort u_sort (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (win_valid_q),
    .last_i   (win_last_q),
    .win_i    (win_q),
    .valid_o  (med_valid),
    .last_o   (med_last),
    .median_o (med_value)
  );

  assign out_valid_o  = out_valid_q;
  assign out_median_o = out_median_q;
  assign out_last_o   = out_last_q;

endmodule
